FILE: rtl/core/i2c_slave_register_bank_macros.svh
// Assertion macros shared by the register bank RTL.
`ifndef I2C_SLAVE_REGISTER_BANK_MACROS_SVH
`define I2C_SLAVE_REGISTER_BANK_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define SRB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SRB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/i2c_srb_pkg.sv
// Event codes and constants for the I2C slave register bank.
package i2c_srb_pkg;

    localparam logic [2:0] REQ_ADDR    = 3'd0;
    localparam logic [2:0] REQ_RX      = 3'd1;
    localparam logic [2:0] REQ_TX      = 3'd2;
    localparam logic [2:0] REQ_NACK    = 3'd3;
    localparam logic [2:0] REQ_STOP    = 3'd4;
    localparam logic [2:0] REQ_TIMEOUT = 3'd5;

    localparam logic [7:0] TX_PAST_BANK = 8'hFF;

endpackage

FILE: rtl/core/i2c_slave_register_bank.sv
// I2C slave register bank: pointer handling, byte bank and result register.
// Pipeline: input register, then bank read and pointer update into the
// result register. Throughput: one request per cycle while the output is
// not stalled by m_tready, set by the single bank port per cycle.
// Reset: pointer 0, expect-pointer flag set, per-entry valid bits cleared so
// every bank entry reads as zero; no clearing pass is needed.
`include "i2c_slave_register_bank_macros.svh"

module i2c_slave_register_bank #(
    parameter int BANK_SIZE = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [15:8] pointer_now
    output logic        m_tuser    // [0] tx_valid
);
    import i2c_srb_pkg::*;

    localparam int         AW         = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;
    localparam logic [7:0] BANK_LIMIT = 8'(BANK_SIZE);
    localparam logic [7:0] BANK_LAST  = 8'(BANK_SIZE - 1);

    logic             in_valid_reg;
    logic [2:0]       in_req_reg;
    logic [7:0]       in_data_reg;

    logic [7:0]       ptr_reg;
    logic [7:0]       ptr_next;
    logic             expect_reg;
    logic             expect_next;
    logic [BANK_SIZE-1:0] vld_reg;

    logic [7:0]       bank_mem [BANK_SIZE];
    logic [7:0]       rd_data_reg;

    logic             out_valid_reg;
    logic             out_txv_reg;
    logic             out_mem_reg;
    logic             out_vld_reg;
    logic [7:0]       out_ptr_reg;

    logic             fire;
    logic             ptr_in_bank;
    logic [AW-1:0]    addr;
    logic [7:0]       ptr_inc;
    logic [7:0]       ptr_dec;
    logic [7:0]       ptr_adv;
    logic [7:0]       ptr_back;
    logic             wr_en;
    logic             tx_req;
    logic             tx_mem;

    assign fire        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !in_valid_reg || fire;
    assign ptr_in_bank = ptr_reg < BANK_LIMIT;
    assign addr        = ptr_reg[AW-1:0];
    assign ptr_inc     = ptr_reg + 8'd1;
    assign ptr_dec     = ptr_reg - 8'd1;
    assign ptr_adv     = (ptr_inc >= BANK_LIMIT) ? 8'd0 : ptr_inc;
    assign ptr_back    = (ptr_dec >= BANK_LIMIT) ? BANK_LAST : ptr_dec;

    // Event decode
    always_comb
    begin
        ptr_next    = ptr_reg;
        expect_next = expect_reg;
        wr_en       = 1'b0;
        tx_req      = 1'b0;
        tx_mem      = 1'b0;
        unique case (in_req_reg)
            REQ_ADDR:
            begin
                expect_next = 1'b1;
            end
            REQ_RX:
            begin
                if (expect_reg)
                begin
                    ptr_next    = in_data_reg;
                    expect_next = 1'b0;
                end
                else
                begin
                    wr_en    = ptr_in_bank;
                    ptr_next = ptr_adv;
                end
            end
            REQ_TX:
            begin
                tx_req = 1'b1;
                if (ptr_in_bank)
                begin
                    tx_mem   = 1'b1;
                    ptr_next = ptr_adv;
                end
            end
            REQ_NACK:
            begin
                ptr_next = ptr_back;
            end
            default:
            begin
                // stop, timeout and unused codes leave state alone
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= 8'd0;
            expect_reg <= 1'b1;
            vld_reg    <= '0;
        end
        else if (fire)
        begin
            ptr_reg    <= ptr_next;
            expect_reg <= expect_next;
            if (wr_en)
            begin
                vld_reg[addr] <= 1'b1;
            end
        end
    end

    // Bank storage: one write or one read per request
    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            bank_mem[addr] <= in_data_reg;
        end
        if (fire && tx_mem)
        begin
            rd_data_reg <= bank_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_txv_reg <= tx_req;
            out_mem_reg <= tx_mem;
            out_vld_reg <= tx_mem && vld_reg[addr];
            out_ptr_reg <= ptr_next;
        end
    end

    // Never-written entries read as zero; past-bank reads return all ones
    assign m_tvalid     = out_valid_reg;
    assign m_tuser      = out_txv_reg;
    assign m_tdata[15:8] = out_ptr_reg;
    assign m_tdata[7:0] = out_mem_reg ? (out_vld_reg ? rd_data_reg : 8'd0)
                                      : (out_txv_reg ? TX_PAST_BANK : 8'd0);

    `SRB_ASSERT(a_tx_past_hold, (fire && in_req_reg == REQ_TX && !ptr_in_bank) |=> $stable(ptr_reg), "pointer moved on past-bank read")
    `SRB_ASSERT(a_tx_adv_range, (fire && in_req_reg == REQ_TX && ptr_in_bank) |=> (ptr_reg < BANK_LIMIT), "advanced pointer out of bank")
    `SRB_ASSERT(a_addr_arms, (fire && in_req_reg == REQ_ADDR) |=> expect_reg, "address match did not arm pointer load")
    `SRB_ASSERT_ALWAYS(a_ready_when_empty, (!out_valid_reg) |-> s_tready, "input stalled with empty result register")

endmodule
